>>> hw/rtl/tun_pkg.sv
// tun_pkg: widths and stage types for the triangle unit normal pipeline.
// No dependencies; used by triangle_unit_normal.
package tun_pkg;

  localparam int CRD_W   = 16;
  localparam int EDGE_W  = CRD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int MAG_W   = PROD_W - 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int LEN_W   = SQ_W + 2;
  localparam int FRAC_SH = 30;
  localparam int REM_W   = 102;
  localparam int K_W     = 16;
  localparam int ITER_N  = K_W;
  localparam int NORM_W  = 16;
  localparam int FRONT_N = 5;
  localparam int NST     = FRONT_N + ITER_N + 1;

  typedef struct packed {
    logic [2:0][REM_W-1:0] rem;
    logic [2:0][REM_W-1:0] prd;
    logic [2:0][K_W-1:0]   k;
    logic [LEN_W-1:0]      len2;
    logic [2:0]            neg;
    logic                  degen;
  } iter_t;

endpackage

>>> hw/rtl/triangle_unit_normal.sv
// triangle_unit_normal: edge vectors, cross product and exact rounded unit normal.
// Depends on tun_pkg.
// 22 register stages; out_valid is the valid bit of the last stage.
// One triangle per cycle while not stalled; five front stages (edges, products,
// magnitudes, squares, length), sixteen square-root-quotient stages, one output
// stage. Synchronous active-low reset clears all valid bits; payload is not reset.
module triangle_unit_normal (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   in_vert0_x,
  input  logic signed [15:0]   in_vert0_y,
  input  logic signed [15:0]   in_vert0_z,
  input  logic signed [15:0]   in_vert1_x,
  input  logic signed [15:0]   in_vert1_y,
  input  logic signed [15:0]   in_vert1_z,
  input  logic signed [15:0]   in_vert2_x,
  input  logic signed [15:0]   in_vert2_y,
  input  logic signed [15:0]   in_vert2_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_norm_x,
  output logic signed [15:0]   out_norm_y,
  output logic signed [15:0]   out_norm_z,
  output logic                 out_degenerate
);

  localparam int NST   = tun_pkg::NST;
  localparam int ITN   = tun_pkg::ITER_N;
  localparam int REM_W = tun_pkg::REM_W;
  localparam int LEN_W = tun_pkg::LEN_W;
  localparam int K_W   = tun_pkg::K_W;
  localparam int SQ_W  = tun_pkg::SQ_W;
  localparam int MAG_W = tun_pkg::MAG_W;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || !out_stall;
    for (int s = NST-2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // edges
  logic signed [tun_pkg::EDGE_W-1:0] e_r [6];
  always_ff @(posedge clk) begin
    if (en[0]) begin
      e_r[0] <= 17'(in_vert1_x) - 17'(in_vert0_x);
      e_r[1] <= 17'(in_vert1_y) - 17'(in_vert0_y);
      e_r[2] <= 17'(in_vert1_z) - 17'(in_vert0_z);
      e_r[3] <= 17'(in_vert2_x) - 17'(in_vert0_x);
      e_r[4] <= 17'(in_vert2_y) - 17'(in_vert0_y);
      e_r[5] <= 17'(in_vert2_z) - 17'(in_vert0_z);
    end
  end

  // cross product terms
  logic signed [tun_pkg::PROD_W-1:0] p_r [6];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_r[0] <= e_r[1] * e_r[5];
      p_r[1] <= e_r[2] * e_r[4];
      p_r[2] <= e_r[2] * e_r[3];
      p_r[3] <= e_r[0] * e_r[5];
      p_r[4] <= e_r[0] * e_r[4];
      p_r[5] <= e_r[1] * e_r[3];
    end
  end

  // magnitudes and signs
  logic signed [tun_pkg::PROD_W-1:0] n_c [3];
  logic [MAG_W-1:0] mag_r [3];
  logic [2:0]       neg2_r;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      n_c[c] = p_r[2*c] - p_r[2*c+1];
    end
  end
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < 3; c++) begin
        neg2_r[c] <= n_c[c][tun_pkg::PROD_W-1];
        mag_r[c]  <= n_c[c][tun_pkg::PROD_W-1] ? MAG_W'(-n_c[c]) : MAG_W'(n_c[c]);
      end
    end
  end

  // squares
  logic [SQ_W-1:0] sq_r [3];
  logic [2:0]      neg3_r;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      neg3_r <= neg2_r;
      for (int c = 0; c < 3; c++) begin
        sq_r[c] <= SQ_W'(mag_r[c]) * SQ_W'(mag_r[c]);
      end
    end
  end

  // squared length and iteration entry
  tun_pkg::iter_t ent_nxt, ent_r;
  always_comb begin
    ent_nxt.len2  = LEN_W'(sq_r[0]) + LEN_W'(sq_r[1]) + LEN_W'(sq_r[2]);
    ent_nxt.neg   = neg3_r;
    ent_nxt.degen = (ent_nxt.len2 == '0);
    for (int c = 0; c < 3; c++) begin
      ent_nxt.rem[c] = REM_W'(sq_r[c]) << tun_pkg::FRAC_SH;
      ent_nxt.prd[c] = '0;
      ent_nxt.k[c]   = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (en[4]) begin
      ent_r <= ent_nxt;
    end
  end

  // quotient bits, most significant first
  tun_pkg::iter_t it_r [ITN];
  for (genvar i = 0; i < ITN; i++) begin : g_it
    localparam int J = ITN - 1 - i;
    tun_pkg::iter_t        cur;
    tun_pkg::iter_t        nxt;
    logic [REM_W-1:0]      len_x;
    logic [2:0][REM_W-1:0] trial;
    if (i == 0) begin : g_first
      assign cur = ent_r;
    end else begin : g_rest
      assign cur = it_r[i-1];
    end
    assign len_x = REM_W'(cur.len2);
    always_comb begin
      nxt = cur;
      for (int c = 0; c < 3; c++) begin
        trial[c] = (cur.prd[c] << (J + 1)) + (len_x << (2 * J));
        if (trial[c] <= cur.rem[c]) begin
          nxt.rem[c] = cur.rem[c] - trial[c];
          nxt.prd[c] = cur.prd[c] + (len_x << J);
          nxt.k[c]   = cur.k[c] | (K_W'(1) << J);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[tun_pkg::FRONT_N + i]) begin
        it_r[i] <= nxt;
      end
    end
  end

  // round, sign, degenerate override
  tun_pkg::iter_t fin;
  logic [2:0][K_W:0]  rnd;
  logic [2:0][15:0]   nrm;
  assign fin = it_r[ITN-1];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c] = (K_W+1)'(fin.k[c]) + (K_W+1)'(1);
      nrm[c] = fin.neg[c] ? 16'(-rnd[c][K_W:1]) : 16'(rnd[c][K_W:1]);
      if (fin.degen) begin
        nrm[c] = '0;
      end
    end
  end

  logic signed [15:0] nx_r, ny_r, nz_r;
  logic               dg_r;
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      nx_r <= nrm[0];
      ny_r <= nrm[1];
      nz_r <= nrm[2];
      dg_r <= fin.degen;
    end
  end

  assign out_valid      = v_r[NST-1];
  assign out_norm_x     = nx_r;
  assign out_norm_y     = ny_r;
  assign out_norm_z     = nz_r;
  assign out_degenerate = dg_r;

endmodule

>>> hw/rtl/tun_checker.sv
// tun_checker: port-level assertions for triangle_unit_normal, bound to the top.
// Depends on triangle_unit_normal port names.
module tun_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic signed [15:0]  out_norm_x,
  input logic signed [15:0]  out_norm_y,
  input logic signed [15:0]  out_norm_z,
  input logic                out_degenerate
);

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall) else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_norm_x) && $stable(out_norm_y)
      && $stable(out_norm_z) && $stable(out_degenerate)) else $error("stalled result changed");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_norm_x == 0 && out_norm_y == 0 && out_norm_z == 0)
    else $error("degenerate result not zero");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_norm_x >= -16'sd16384 && out_norm_x <= 16'sd16384
      && out_norm_y >= -16'sd16384 && out_norm_y <= 16'sd16384
      && out_norm_z >= -16'sd16384 && out_norm_z <= 16'sd16384)
    else $error("normal component out of range");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid) else $error("stalled input transfer withdrawn");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (.*);

>>> dv/triangle_unit_normal_tb.sv
// Testbench for triangle_unit_normal: drives triangles, predicts the rounded unit normal
// exactly with wide integer arithmetic, and compares each result transfer in order.
// Depends on the triangle_unit_normal RTL only.
module triangle_unit_normal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] v0x = '0, v0y = '0, v0z = '0;
  logic signed [15:0] v1x = '0, v1y = '0, v1z = '0;
  logic signed [15:0] v2x = '0, v2y = '0, v2z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;
  logic out_degenerate;

  normal_t normal_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_degen = 0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  bit sink_hold = 1'b0;

  triangle_unit_normal dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vert0_x(v0x), .in_vert0_y(v0y), .in_vert0_z(v0z),
    .in_vert1_x(v1x), .in_vert1_y(v1y), .in_vert1_z(v1z),
    .in_vert2_x(v2x), .in_vert2_y(v2y), .in_vert2_z(v2z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_norm_x(out_norm_x), .out_norm_y(out_norm_y), .out_norm_z(out_norm_z),
    .out_degenerate(out_degenerate)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // largest m in 0..16384 with len2*(2m-1)^2 <= (c*2^15)^2
  function automatic logic signed [15:0] unit_comp(logic signed [35:0] c,
                                                   logic [127:0] len2);
    logic [127:0] mag, rhs, lhs, d;
    int lo, hi, m;
    mag = (c < 0) ? 128'(-c) : 128'(c);
    rhs = (mag << 15) * (mag << 15);
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      m = (lo + hi + 1) / 2;
      d = 128'(2 * m - 1);
      lhs = len2 * d * d;
      if (lhs <= rhs) lo = m;
      else hi = m - 1;
    end
    return (c < 0) ? 16'(-lo) : 16'(lo);
  endfunction

  function automatic normal_t face_normal(logic signed [15:0] ax0, ay0, az0,
                                          bx0, by0, bz0, cx0, cy0, cz0);
    logic signed [35:0] ex, ey, ez, fx, fy, fz, nx, ny, nz;
    logic [127:0] len2;
    normal_t r;
    ex = bx0 - ax0; ey = by0 - ay0; ez = bz0 - az0;
    fx = cx0 - ax0; fy = cy0 - ay0; fz = cz0 - az0;
    nx = ey * fz - ez * fy;
    ny = ez * fx - ex * fz;
    nz = ex * fy - ey * fx;
    len2 = 128'(nx) * 128'(nx) + 128'(ny) * 128'(ny) + 128'(nz) * 128'(nz);
    r = '0;
    if (len2 == 0) begin
      r.degen = 1'b1;
    end else begin
      r.nx = unit_comp(nx, len2);
      r.ny = unit_comp(ny, len2);
      r.nz = unit_comp(nz, len2);
    end
    return r;
  endfunction

  task automatic send_triangle(logic signed [15:0] a0, a1, a2, b0, b1, b2,
                               c0, c1, c2);
    int gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    v0x <= a0; v0y <= a1; v0z <= a2;
    v1x <= b0; v1y <= b1; v1z <= b2;
    v2x <= c0; v2y <= c1; v2z <= c2;
    normal_q.insert(normal_q.size(), face_normal(a0, a1, a2, b0, b1, b2, c0, c1, c2));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic signed [15:0] p[9];
    foreach (p[i]) p[i] = pick_coord();
    case ($urandom_range(0, 9))
      0: begin p[3] = p[0]; p[4] = p[1]; p[5] = p[2]; end
      1: begin
        p[3] = p[0] + 16'sd3; p[4] = p[1] - 16'sd2; p[5] = p[2] + 16'sd1;
        p[6] = p[0] + 16'sd6; p[7] = p[1] - 16'sd4; p[8] = p[2] + 16'sd2;
      end
      default: ;
    endcase
    send_triangle(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_triangle(0, 0, 0, 0, 256, 0, 256, 0, 0);
    send_triangle(0, 0, 0, 0, 0, 256, 256, 0, 0);
    send_triangle(0, 0, 0, 256, 0, 0, 0, 0, 256);
    send_triangle(0, 0, 0, 256, 0, 0, 512, 0, 0);
    send_triangle(1, 2, 3, 2, 4, 6, 3, 6, 9);
    send_triangle(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh7FFF, 16'sh8000);
    send_triangle(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                  16'sh7FFF, 16'sh8000, 16'sh8000);
    send_triangle(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                  16'sh8000, 16'sh8000, 16'sh7FFF);
    send_triangle(0, 0, 0, 1, 0, 0, 0, 1, 1);
    send_triangle(0, 0, 0, 1, 1, 0, 0, 1, 1);
    send_triangle(0, 0, 0, 1, 2, 2, 2, 1, 2);
    send_triangle(0, 0, 0, 3, 0, 0, 0, 4, 5);
    send_triangle(-1, -1, -1, -1, -1, -1, 0, 0, 0);
    send_triangle(16'sh5555, 16'shAAAA, 16'sh0F0F, 16'shF0F0, 16'sh3C3C, 16'shC3C3,
                  16'sh00FF, 16'shFF00, 16'sh1234);
    wait_drained();
  endtask

  task automatic test_random(int count);
    repeat (count) send_random();
  endtask

  task automatic test_backpressure();
    sink_hold = 1'b1;
    repeat (60) send_random();
    wait_drained();
  endtask

  task automatic test_streaming(int count);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (count) send_random();
    wait_drained();
  endtask

  // receiver: random stall bursts, plus one long hold-off when requested
  initial begin
    int gap;
    int held;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        sink_hold = 1'b0;
        out_stall <= 1'b1;
        held = 0;
        while (held < 80) begin
          @(posedge clk);
          held++;
        end
        out_stall <= 1'b0;
      end else if (sink_idle_en && !out_stall && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (normal_q.size() == 0) begin
        $display("%0t: result with none expected: %0d %0d %0d %0b", $time,
                 out_norm_x, out_norm_y, out_norm_z, out_degenerate);
        errors++;
      end else begin
        want = normal_q.pop_front();
        n_recv++;
        if (want.degen) n_degen++;
        if (out_norm_x !== want.nx || out_norm_y !== want.ny ||
            out_norm_z !== want.nz || out_degenerate !== want.degen) begin
          $display("%0t: mismatch expected %0d %0d %0d %0b actual %0d %0d %0d %0b", $time,
                   want.nx, want.ny, want.nz, want.degen,
                   out_norm_x, out_norm_y, out_norm_z, out_degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_backpressure();
    test_random(200);
    test_streaming(80);
    repeat (40) @(posedge clk);
    if (normal_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, normal_q.size());
      errors++;
    end
    $display("covered %0d triangles sent, %0d results checked, %0d degenerate",
             n_sent, n_recv, n_degen);
    $display("with random stalls, a long output hold-off and a gap-free stream");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
